### design/bwbp_pkg.sv
// bwbp_pkg: shared constants and the coefficient write bus type for the
// butterworth bandpass cascade; no dependencies
`default_nettype none

package bwbp_pkg;

    localparam int SECTIONS    = 2;
    localparam int SEC_W       = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int SAMPLE_W    = 24;
    localparam int SAMPLE_FRAC = 12;
    localparam int W_W         = 48;
    localparam int COEF_W      = 32;
    localparam int N_COEF      = 5;
    localparam int COEF_IDX_W  = 3;
    localparam int A_W         = 32;
    localparam int B_W         = 31;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;

    localparam logic [A_W-1:0] CENTER_RST = 32'd0;
    localparam logic [B_W-1:0] WIDTH_RST  = 31'd26843546;

    localparam logic [COEF_IDX_W-1:0] C_GAIN = 3'd0;
    localparam logic [COEF_IDX_W-1:0] C_D1   = 3'd1;
    localparam logic [COEF_IDX_W-1:0] C_D2   = 3'd2;
    localparam logic [COEF_IDX_W-1:0] C_D3   = 3'd3;
    localparam logic [COEF_IDX_W-1:0] C_D4   = 3'd4;

    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef struct packed {
        logic                     en;
        logic [SEC_W-1:0]         sec;
        logic [COEF_IDX_W-1:0]    idx;
        logic signed [COEF_W-1:0] val;
    } t_coef_wr;

endpackage

`default_nettype wire

### design/bwbp_coef.sv
// bwbp_coef: band registers and the sequencer that derives every section's
// five coefficients with one shared multiplier and a radix-2 divider; uses bwbp_pkg
`default_nettype none

module bwbp_coef (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bwbp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bwbp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                               o_busy,
    output bwbp_pkg::t_coef_wr                 o_wr
);
    import bwbp_pkg::*;

    localparam logic [3:0] S_B2   = 4'd0;
    localparam logic [3:0] S_A2   = 4'd1;
    localparam logic [3:0] S_A2W  = 4'd2;
    localparam logic [3:0] S_BR   = 4'd3;
    localparam logic [3:0] S_S    = 4'd4;
    localparam logic [3:0] S_P1   = 4'd5;
    localparam logic [3:0] S_P3   = 4'd6;
    localparam logic [3:0] S_P3W  = 4'd7;
    localparam logic [3:0] S_NUM  = 4'd8;
    localparam logic [3:0] S_DIV  = 4'd9;
    localparam logic [3:0] S_IDLE = 4'd10;

    localparam int NW = 39;
    localparam int DW = 66;
    localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(SECTIONS - 1);
    localparam logic [32:0] ONE33 = 33'd268435456;

    logic [30:0] w_sine [SECTIONS];

    // r_i = sin(pi*(2i+1)/(4*SECTIONS)) in Q1.30, taylor series to x^15
    for (genvar g = 0; g < SECTIONS; g++) begin : g_sine
        localparam longint unsigned SX  = (PI_Q30 * 64'(2 * g + 1)) / 64'(4 * SECTIONS);
        localparam longint unsigned SX2 = (SX * SX) >> 30;
        localparam longint unsigned ST1 = ((SX * SX2) >> 30) / 64'd6;
        localparam longint unsigned ST2 = ((ST1 * SX2) >> 30) / 64'd20;
        localparam longint unsigned ST3 = ((ST2 * SX2) >> 30) / 64'd42;
        localparam longint unsigned ST4 = ((ST3 * SX2) >> 30) / 64'd72;
        localparam longint unsigned ST5 = ((ST4 * SX2) >> 30) / 64'd110;
        localparam longint unsigned ST6 = ((ST5 * SX2) >> 30) / 64'd156;
        localparam longint unsigned ST7 = ((ST6 * SX2) >> 30) / 64'd210;
        localparam longint SSUM = longint'(SX) - longint'(ST1) + longint'(ST2)
                                - longint'(ST3) + longint'(ST4) - longint'(ST5)
                                + longint'(ST6) - longint'(ST7);
        localparam longint SCLP = (SSUM < 0) ? 64'sd0
                                : (SSUM > (64'sd1 <<< 30)) ? (64'sd1 <<< 30) : SSUM;
        localparam logic [30:0] SINE_VAL = 31'(SCLP);
        assign w_sine[g] = SINE_VAL;
    end

    logic [3:0]             r_state;
    logic [3:0]             n_state;
    logic [A_W-1:0]         r_a;
    logic [B_W-1:0]         r_b;
    logic [63:0]            r_prod;
    logic [34:0]            r_b2;
    logic [30:0]            r_a2;
    logic [31:0]            r_br;
    logic [35:0]            r_s;
    logic signed [35:0]     r_p1;
    logic signed [35:0]     r_p3;
    logic                   r_p3_neg;
    logic [SEC_W-1:0]       r_sec;
    logic [COEF_IDX_W-1:0]  r_k;
    logic [DW-1:0]          r_rem;
    logic [DW-1:0]          r_dsr;
    logic [30:0]            r_q;
    logic [4:0]             r_cnt;
    logic                   r_neg;
    t_coef_wr               r_wr;

    logic [31:0]            w_amag;
    logic [32:0]            w_opl;
    logic [32:0]            w_omr;
    logic [32:0]            w_omr_n;
    logic [31:0]            w_omag;
    logic [31:0]            w_mx;
    logic [31:0]            w_my;
    logic signed [NW-1:0]   w_b2s;
    logic signed [NW-1:0]   w_a2s;
    logic signed [NW-1:0]   w_brs;
    logic signed [NW-1:0]   w_ones;
    logic signed [NW-1:0]   w_p1s;
    logic signed [NW-1:0]   w_p3s;
    logic signed [NW-1:0]   w_num;
    logic signed [NW-1:0]   w_num_n;
    logic                   w_neg;
    logic [NW-2:0]          w_mag;
    logic                   w_ovf;
    logic                   w_ge;
    logic [30:0]            w_qn;
    logic [31:0]            w_qpos;
    logic                   w_cfg_hit;
    logic                   w_fin;

    assign w_amag  = r_a[A_W-1] ? (~r_a + 32'd1) : r_a;
    assign w_opl   = ONE33 + {1'b0, r_br};
    assign w_omr   = ONE33 - {1'b0, r_br};
    assign w_omr_n = ~w_omr + 33'd1;
    assign w_omag  = w_omr[32] ? w_omr_n[31:0] : w_omr[31:0];

    always_comb begin
        unique case (r_state)
            S_B2: begin
                w_mx = {1'b0, r_b};
                w_my = {1'b0, r_b};
            end
            S_A2: begin
                w_mx = w_amag;
                w_my = w_amag;
            end
            S_BR: begin
                w_mx = {1'b0, r_b};
                w_my = {1'b0, w_sine[r_sec]};
            end
            S_P1: begin
                w_mx = w_amag;
                w_my = w_opl[31:0];
            end
            S_P3: begin
                w_mx = w_amag;
                w_my = w_omag;
            end
            default: begin
                w_mx = 32'd0;
                w_my = 32'd0;
            end
        endcase
    end

    assign w_b2s  = $signed({4'd0, r_b2});
    assign w_a2s  = $signed({8'd0, r_a2});
    assign w_brs  = $signed({7'd0, r_br});
    assign w_ones = 39'sd268435456;
    assign w_p1s  = {{3{r_p1[35]}}, r_p1};
    assign w_p3s  = {{3{r_p3[35]}}, r_p3};

    always_comb begin
        unique case (r_k)
            C_GAIN:  w_num = w_b2s;
            C_D1:    w_num = w_p1s <<< 2;
            C_D2:    w_num = (w_b2s - (w_a2s <<< 1) - w_ones) <<< 1;
            C_D3:    w_num = w_p3s <<< 2;
            C_D4:    w_num = (w_brs <<< 1) - w_b2s - w_ones;
            default: w_num = '0;
        endcase
    end

    assign w_num_n = -w_num;
    assign w_neg   = w_num[NW-1];
    assign w_mag   = w_neg ? w_num_n[NW-2:0] : w_num[NW-2:0];
    assign w_ovf   = {1'b0, w_mag} >= {r_s, 3'd0};
    assign w_ge    = r_rem >= r_dsr;
    assign w_qn    = {r_q[29:0], w_ge};
    assign w_qpos  = {1'b0, w_qn};
    assign w_fin   = (r_state == S_NUM && w_ovf) || (r_state == S_DIV && r_cnt == 5'd0);

    assign w_cfg_hit = i_cfg_we && (i_cfg_index == REG_CENTER || i_cfg_index == REG_WIDTH);

    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            S_B2:   n_state = S_A2;
            S_A2:   n_state = S_A2W;
            S_A2W:  n_state = S_BR;
            S_BR:   n_state = S_S;
            S_S:    n_state = S_P1;
            S_P1:   n_state = S_P3;
            S_P3:   n_state = S_P3W;
            S_P3W:  n_state = S_NUM;
            S_NUM, S_DIV: begin
                if (w_fin) begin
                    if (r_k != C_D4) begin
                        n_state = S_NUM;
                    end else if (r_sec == SEC_LAST) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_BR;
                    end
                end else begin
                    n_state = S_DIV;
                end
            end
            S_IDLE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (w_cfg_hit) begin
            n_state = S_B2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_B2;
            r_a      <= CENTER_RST;
            r_b      <= WIDTH_RST;
            r_sec    <= '0;
            r_k      <= C_GAIN;
            r_wr.en  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wr.en <= w_fin;
            r_prod  <= w_mx * w_my;
            if (i_cfg_we && i_cfg_index == REG_CENTER) begin
                r_a <= i_cfg_data[A_W-1:0];
            end
            if (i_cfg_we && i_cfg_index == REG_WIDTH) begin
                r_b <= i_cfg_data[B_W-1:0];
            end
            case (r_state)
                S_A2: r_b2 <= r_prod[62:28];
                S_A2W: begin
                    r_a2  <= r_prod[62:32];
                    r_sec <= '0;
                end
                S_S:  r_br <= r_prod[61:30];
                S_P1: r_s <= {1'b0, r_b2} + {3'd0, r_br, 1'b0} + 36'd268435456;
                S_P3: begin
                    r_p1     <= r_a[A_W-1] ? -$signed({2'b0, r_prod[63:30]})
                                           : $signed({2'b0, r_prod[63:30]});
                    r_p3_neg <= r_a[A_W-1] != w_omr[32];
                end
                S_P3W: begin
                    r_p3 <= r_p3_neg ? -$signed({2'b0, r_prod[63:30]})
                                     : $signed({2'b0, r_prod[63:30]});
                    r_k  <= C_GAIN;
                end
                S_NUM: begin
                    r_neg <= w_neg;
                    r_rem <= {w_mag, 28'd0};
                    r_dsr <= {r_s, 30'd0};
                    r_q   <= '0;
                    r_cnt <= 5'd30;
                    if (w_ovf) begin
                        r_wr.sec <= r_sec;
                        r_wr.idx <= r_k;
                        r_wr.val <= w_neg ? 32'sh80000000 : 32'sh7fffffff;
                    end
                end
                S_DIV: begin
                    if (w_ge) begin
                        r_rem <= r_rem - r_dsr;
                    end
                    r_dsr <= r_dsr >> 1;
                    r_q   <= w_qn;
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_wr.sec <= r_sec;
                        r_wr.idx <= r_k;
                        r_wr.val <= r_neg ? -$signed(w_qpos) : $signed(w_qpos);
                    end
                end
                default: ;
            endcase
            if (w_fin) begin
                if (r_k == C_D4) begin
                    r_k <= C_GAIN;
                    if (r_sec != SEC_LAST) begin
                        r_sec <= r_sec + 1'b1;
                    end
                end else begin
                    r_k <= r_k + 3'd1;
                end
            end
        end
    end

    assign o_busy = r_state != S_IDLE;
    assign o_wr   = r_wr;

endmodule

`default_nettype wire

### design/bwbp_cell.sv
// bwbp_cell: one fourth-order section; holds its history and coefficients and
// runs an eight-step multiply-accumulate sequence per word; uses bwbp_pkg
`default_nettype none

module bwbp_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [bwbp_pkg::SEC_W-1:0]         i_sec,
    input  bwbp_pkg::t_coef_wr                 i_wr,
    input  logic                               i_start,
    input  logic signed [bwbp_pkg::W_W-1:0]    i_x,
    input  logic                               i_last,
    output logic                               o_done,
    output logic signed [bwbp_pkg::W_W-1:0]    o_x,
    output logic                               o_last
);
    import bwbp_pkg::*;

    localparam logic [2:0] ST_MAC_LAST = 3'd3;
    localparam logic [2:0] ST_W0       = 3'd4;
    localparam logic [2:0] ST_DIFF     = 3'd5;
    localparam logic [2:0] ST_GAIN     = 3'd6;
    localparam logic [2:0] ST_OUT      = 3'd7;

    function automatic logic signed [W_W-1:0] sat48(input logic signed [63:0] v);
        if ((&v[63:W_W-1]) || !(|v[63:W_W-1])) begin
            return v[W_W-1:0];
        end
        return v[63] ? {1'b1, {(W_W-1){1'b0}}} : {1'b0, {(W_W-1){1'b1}}};
    endfunction

    logic signed [COEF_W-1:0] r_c [N_COEF];
    logic signed [W_W-1:0]    r_h [4];
    logic                     r_run;
    logic [2:0]               r_step;
    logic signed [W_W-1:0]    r_x;
    logic                     r_last;
    logic signed [63:0]       r_hi;
    logic signed [63:0]       r_lo;
    logic signed [W_W-1:0]    r_w0;
    logic signed [50:0]       r_diff;
    logic                     r_done;
    logic signed [W_W-1:0]    r_xo;
    logic                     r_lasto;

    logic                     w_mac;
    logic signed [W_W-1:0]    w_hv;
    logic signed [COEF_W-1:0] w_mc;
    logic signed [26:0]       w_mh;
    logic [23:0]              w_ml;
    logic signed [58:0]       w_phi;
    logic signed [56:0]       w_plo;
    logic signed [63:0]       w_phi64;
    logic signed [63:0]       w_plo64;
    logic signed [63:0]       w_acc;
    logic signed [63:0]       w_f;

    assign w_mac   = r_step <= ST_MAC_LAST;
    assign w_hv    = r_h[r_step[1:0]];
    assign w_mc    = w_mac ? r_c[COEF_IDX_W'(r_step[1:0]) + 3'd1] : r_c[C_GAIN];
    assign w_mh    = w_mac ? {{3{w_hv[W_W-1]}}, w_hv[W_W-1:24]} : r_diff[50:24];
    assign w_ml    = w_mac ? w_hv[23:0] : r_diff[23:0];
    assign w_phi   = w_mc * w_mh;
    assign w_plo   = w_mc * $signed({1'b0, w_ml});
    assign w_phi64 = {{5{w_phi[58]}}, w_phi};
    assign w_plo64 = {{7{w_plo[56]}}, w_plo};
    assign w_acc   = r_hi + (r_lo >>> 24);
    assign w_f     = w_acc >>> 4;

    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr.sec == i_sec) begin
            r_c[i_wr.idx] <= i_wr.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_h[k] <= '0;
            end
        end else begin
            r_done <= !i_start && r_run && (r_step == ST_OUT);
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= '0;
                r_x    <= i_x;
                r_last <= i_last;
            end else if (r_run) begin
                r_step <= r_step + 3'd1;
                if (w_mac) begin
                    r_hi <= (r_step == 3'd0) ? w_phi64 : r_hi + w_phi64;
                    r_lo <= (r_step == 3'd0) ? w_plo64 : r_lo + w_plo64;
                end
                case (r_step)
                    ST_W0:   r_w0 <= sat48(w_f + {{16{r_x[W_W-1]}}, r_x});
                    ST_DIFF: r_diff <= {{3{r_w0[W_W-1]}}, r_w0}
                                     - {{2{r_h[1][W_W-1]}}, r_h[1], 1'b0}
                                     + {{3{r_h[3][W_W-1]}}, r_h[3]};
                    ST_GAIN: begin
                        r_hi <= w_phi64;
                        r_lo <= w_plo64;
                    end
                    ST_OUT: begin
                        r_run   <= 1'b0;
                        r_xo    <= sat48(w_f);
                        r_lasto <= r_last;
                        if (r_last) begin
                            for (int k = 0; k < 4; k++) begin
                                r_h[k] <= '0;
                            end
                        end else begin
                            r_h[3] <= r_h[2];
                            r_h[2] <= r_h[1];
                            r_h[1] <= r_h[0];
                            r_h[0] <= r_w0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_xo;
    assign o_last = r_lasto;

endmodule

`default_nettype wire

### design/butterworth_bandpass_cascade.sv
// butterworth_bandpass_cascade: top level; coefficient unit, chain of section
// cells, output rounding and result register; uses bwbp_pkg, bwbp_coef, bwbp_cell
//
//   channel   direction   handshake                 payload
//   in        sink        i_in_valid / o_in_stall   i_sample_in, i_last_sample
//   out       source      o_out_valid / i_out_stall o_sample_out, o_last_out, o_clipped
//   cfg       sink        i_cfg_we                  i_cfg_index, i_cfg_data
//
// one word is in flight at a time; in each section cell it is started, then
// the shared multiplier pair is stepped over four history taps and the gain;
// the next word is accepted once the result has moved from the hold register
// to the output register
// after reset and after each write to the center or width register the
// coefficient unit recomputes every coefficient (radix-2 divider, ending early
// when a coefficient saturates), with the input stalled meanwhile
// the result register lets a new word enter while a result waits downstream
`default_nettype none

module butterworth_bandpass_cascade (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [bwbp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [bwbp_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [bwbp_pkg::SAMPLE_W-1:0]  i_sample_in,
    input  logic                                  i_last_sample,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [bwbp_pkg::SAMPLE_W-1:0]  o_sample_out,
    output logic                                  o_last_out,
    output logic                                  o_clipped
);
    import bwbp_pkg::*;

    t_coef_wr               w_wr;
    logic                   w_coef_busy;
    logic                   w_in_acc;
    logic                   w_go   [SECTIONS+1];
    logic signed [W_W-1:0]  w_x    [SECTIONS+1];
    logic                   w_last [SECTIONS+1];
    logic signed [W_W:0]    w_sum;
    logic signed [36:0]     w_o;
    logic                   w_clip;
    logic                   w_move;

    logic                   r_busy;
    logic                   r_hold_valid;
    logic [SAMPLE_W-1:0]    r_hold_sample;
    logic                   r_hold_last;
    logic                   r_hold_clip;
    logic                   r_out_valid;
    logic [SAMPLE_W-1:0]    r_out_sample;
    logic                   r_out_last;
    logic                   r_out_clip;

    bwbp_coef u_coef (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_busy      (w_coef_busy),
        .o_wr        (w_wr)
    );

    assign o_in_stall = r_busy || w_coef_busy;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_go[0]   = w_in_acc;
    assign w_x[0]    = {{(W_W-SAMPLE_W-SAMPLE_FRAC){i_sample_in[SAMPLE_W-1]}},
                        i_sample_in, {SAMPLE_FRAC{1'b0}}};
    assign w_last[0] = i_last_sample;

    for (genvar g = 0; g < SECTIONS; g++) begin : g_cell
        bwbp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_sec   (SEC_W'(g)),
            .i_wr    (w_wr),
            .i_start (w_go[g]),
            .i_x     (w_x[g]),
            .i_last  (w_last[g]),
            .o_done  (w_go[g+1]),
            .o_x     (w_x[g+1]),
            .o_last  (w_last[g+1])
        );
    end

    // round half up to integer samples, then clamp to 24 bits
    assign w_sum  = {w_x[SECTIONS][W_W-1], w_x[SECTIONS]} + 49'sd2048;
    assign w_o    = w_sum[W_W:SAMPLE_FRAC];
    assign w_clip = !((&w_o[36:SAMPLE_W-1]) || !(|w_o[36:SAMPLE_W-1]));
    assign w_move = r_hold_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_busy <= 1'b1;
            end
            if (w_go[SECTIONS]) begin
                r_hold_valid  <= 1'b1;
                r_hold_last   <= w_last[SECTIONS];
                r_hold_clip   <= w_clip;
                r_hold_sample <= w_clip ? (w_o[36] ? 24'h800000 : 24'h7fffff)
                                        : w_o[SAMPLE_W-1:0];
            end
            if (w_move) begin
                r_hold_valid <= 1'b0;
                r_busy       <= 1'b0;
                r_out_valid  <= 1'b1;
                r_out_sample <= r_hold_sample;
                r_out_last   <= r_hold_last;
                r_out_clip   <= r_hold_clip;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_last_out   = r_out_last;
    assign o_clipped    = r_out_clip;

    a_done_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go[SECTIONS] |-> r_busy && !r_hold_valid)
        else $error("section chain finished with no word in flight");

    a_hold_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_valid |-> r_busy)
        else $error("result waiting while block reports idle");

    a_release_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> r_out_valid)
        else $error("word released without a result in the output register");

endmodule

`default_nettype wire
